[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/tlbt_pkg.sv]
// Shared operation codes, status codes, a base page mask and a helper of the TLB block.
package tlbt_pkg;
    typedef logic [2:0] t_kind;
    localparam t_kind K_TRANSLATE = 3'd0;
    localparam t_kind K_PROBE     = 3'd1;
    localparam t_kind K_WRITE_IDX = 3'd2;
    localparam t_kind K_WRITE_RND = 3'd3;
    localparam t_kind K_READ      = 3'd4;
    localparam t_kind K_CLEAR     = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status ST_HIT      = 2'd0;
    localparam t_status ST_MISS     = 2'd1;
    localparam t_status ST_INVALID  = 2'd2;
    localparam t_status ST_MODIFIED = 2'd3;

    localparam logic [31:0] BASE_PAGE_MASK = 32'h0000_1FFF;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int k = 0; k < 32; k++) begin
            n = n + 6'(v[k]);
        end
        return n;
    endfunction
endpackage

[hw/rtl/tlbt_if.sv]
// Request and response channel interfaces of the TLB block.
interface tlbt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] virt_addr;
    logic        is_write;
    logic [7:0]  cur_asid;
    logic [63:0] entry_hi;
    logic [31:0] page_mask;
    logic [63:0] entry_lo_even;
    logic [63:0] entry_lo_odd;
    logic [5:0]  slot;
    logic [5:0]  random_pick;
    modport source(output valid, kind, virt_addr, is_write, cur_asid, entry_hi, page_mask,
                   entry_lo_even, entry_lo_odd, slot, random_pick, input ready);
    modport sink(input valid, kind, virt_addr, is_write, cur_asid, entry_hi, page_mask,
                 entry_lo_even, entry_lo_odd, slot, random_pick, output ready);
endinterface

interface tlbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] phys_addr;
    logic        dirty_prot;
    logic [5:0]  index_out;
    logic        probe_miss;
    logic [63:0] read_entry_hi;
    logic [31:0] read_page_mask;
    logic [63:0] read_entry_lo_even;
    logic [63:0] read_entry_lo_odd;
    modport source(output valid, status, phys_addr, dirty_prot, index_out, probe_miss,
                   read_entry_hi, read_page_mask, read_entry_lo_even, read_entry_lo_odd,
                   input ready);
    modport sink(input valid, status, phys_addr, dirty_prot, index_out, probe_miss,
                 read_entry_hi, read_page_mask, read_entry_lo_even, read_entry_lo_odd,
                 output ready);
endinterface

[hw/rtl/tlbt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module tlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[hw/rtl/tlbt_cmp.sv]
// Tag compare unit: one stored entry against a lookup key.
module tlbt_cmp #(
    parameter int VADDR_BITS = 40
) (
    input  logic [31:0]           i_mask,
    input  logic [VADDR_BITS-1:0] i_vpn,
    input  logic [7:0]            i_asid,
    input  logic [1:0]            i_region,
    input  logic                  i_global,
    input  logic                  i_live,
    input  logic [VADDR_BITS-1:0] i_key_hi,
    input  logic [7:0]            i_key_asid,
    input  logic [1:0]            i_key_region,
    input  logic                  i_chk_live,
    input  logic                  i_chk_region,
    output logic                  o_match
);
    import tlbt_pkg::*;

    logic [VADDR_BITS-1:0] m;
    logic                  tag_ok;

    assign m      = VADDR_BITS'(i_mask | BASE_PAGE_MASK);
    assign tag_ok = (i_global || (i_asid == i_key_asid)) && ((i_vpn & ~m) == (i_key_hi & ~m));
    assign o_match = tag_ok && (!i_chk_live || i_live)
                     && (!i_chk_region || (i_region == i_key_region));
endmodule

[hw/rtl/mips_tlb_translate_probe_write.sv]
// Top level: fully associative paired-page TLB with a sequential entry scan.
// Translate and probe read one entry per cycle from the entry RAM through one compare unit:
// the response is registered and held until taken, and no request is taken before then.
// Ready only when idle. Write indexed and read use the slot if in range; write random reduces
// random_pick mod ENTRIES, lifts a slot below wired, then writes; clear resets all entries.
// Reset (synchronous, active low) clears all entry valid bits and wired_count at once.
module mips_tlb_translate_probe_write #(
    parameter int ENTRIES    = 64,
    parameter int VADDR_BITS = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    tlbt_req_if.sink   i_req,
    tlbt_rsp_if.source o_rsp
);
    import tlbt_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = ((IW > 6) ? IW : 6) + 1;           // slot math, holds slot + wired
    localparam int RW = 64 + 64 + 32 + VADDR_BITS + 8 + 2 + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_FIN, S_RMOD, S_RADJ, S_WR, S_RD, S_RDOUT, S_OUT
    } t_state;

    t_state r_state;

    // Captured request
    t_kind                 r_kind;
    logic [63:0]           r_va;
    logic                  r_is_write;
    logic [7:0]            r_cur_asid;
    logic [63:0]           r_hi;
    logic [31:0]           r_mask;
    logic [63:0]           r_lo_even;
    logic [63:0]           r_lo_odd;
    logic [SW-1:0]         r_slot;
    logic [SW-1:0]         r_s;

    logic [5:0]            r_wired;
    logic [ENTRIES-1:0]    r_written;   // entry holds written data, else reads as zero
    logic [ENTRIES-1:0]    r_live;

    // Scan control
    logic [IW:0]           r_addr;
    logic                  r_pend;
    logic [IW-1:0]         r_cidx;
    logic                  r_found;
    logic [RW-1:0]         r_hit;

    // Response register
    logic                  r_rsp_valid;
    logic [1:0]            r_status;
    logic [63:0]           r_phys;
    logic                  r_dirty;
    logic [5:0]            r_index_out;
    logic                  r_probe_miss;
    logic [63:0]           r_rd_hi;
    logic [31:0]           r_rd_mask;
    logic [63:0]           r_rd_lo_even;
    logic [63:0]           r_rd_lo_odd;

    // RAM ports
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [RW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [RW-1:0]         ram_rdata;
    logic [RW-1:0]         ent;

    // Entry fields
    logic [63:0]           e_lo_odd;
    logic [63:0]           e_lo_even;
    logic [31:0]           e_mask;
    logic [VADDR_BITS-1:0] e_vpn;
    logic [7:0]            e_asid;
    logic [1:0]            e_region;
    logic                  e_global;

    logic                  is_trans;
    logic                  cmp_match;
    logic                  scan_more;

    // Translate finish, from the held hit entry
    logic [63:0]           h_lo_odd;
    logic [63:0]           h_lo_even;
    logic [31:0]           h_mask;
    logic [63:0]           h_m;
    logic                  h_odd;
    logic [63:0]           h_lo;
    logic [63:0]           h_pfn;
    logic [1:0]            h_status;

    logic [SW-1:0]         adj_s;

    assign is_trans  = (r_kind == K_TRANSLATE);
    assign scan_more = (r_addr < (IW + 1)'(ENTRIES));

    assign ram_re    = ((r_state == S_SCAN) && scan_more) || (r_state == S_RD);
    assign ram_raddr = (r_state == S_RD) ? IW'(r_slot) : r_addr[IW-1:0];
    assign ram_we    = (r_state == S_WR);
    assign ram_waddr = IW'(r_s);
    assign ram_wdata = {r_lo_odd, r_lo_even, r_mask,
                        r_hi[VADDR_BITS-1:0] & ~VADDR_BITS'(BASE_PAGE_MASK),
                        r_hi[7:0], r_hi[63:62], r_lo_even[0] & r_lo_odd[0]};

    tlbt_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Entries never written since reset or clear read as zero
    assign ent = r_written[r_cidx] ? ram_rdata : '0;
    assign {e_lo_odd, e_lo_even, e_mask, e_vpn, e_asid, e_region, e_global} = ent;

    // Translate keys on the address, probe on EntryHi; probe ignores region and, in its
    // first pass, the live bit
    tlbt_cmp #(.VADDR_BITS(VADDR_BITS)) u_cmp (
        .i_mask      (e_mask),
        .i_vpn       (e_vpn),
        .i_asid      (e_asid),
        .i_region    (e_region),
        .i_global    (e_global),
        .i_live      (r_live[r_cidx]),
        .i_key_hi    (is_trans ? r_va[VADDR_BITS-1:0] : r_hi[VADDR_BITS-1:0]),
        .i_key_asid  (is_trans ? r_cur_asid : r_hi[7:0]),
        .i_key_region(r_va[63:62]),
        .i_chk_live  (is_trans || r_found),
        .i_chk_region(is_trans),
        .o_match     (cmp_match)
    );

    // Page select and physical address of the hit entry
    assign h_lo_odd  = r_hit[RW-1 -: 64];
    assign h_lo_even = r_hit[RW-65 -: 64];
    assign h_mask    = r_hit[RW-129 -: 32];
    assign h_m       = {32'd0, (h_mask | BASE_PAGE_MASK) >> 1};
    assign h_odd     = r_va[popcount32(h_m[31:0])];
    assign h_lo      = h_odd ? h_lo_odd : h_lo_even;
    assign h_pfn     = {h_lo[57:6], 12'd0} & ~{32'd0, h_mask >> 1};

    always_comb begin
        if (!h_lo[1]) begin
            h_status = ST_INVALID;
        end else if (r_is_write && !h_lo[2]) begin
            h_status = ST_MODIFIED;
        end else begin
            h_status = ST_HIT;
        end
    end

    // Random slot: raise below wired, saturate at the top entry
    always_comb begin
        adj_s = (r_s < SW'(r_wired)) ? (r_s + SW'(r_wired)) : r_s;
        if (adj_s >= SW'(ENTRIES)) begin
            adj_s = SW'(ENTRIES - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wired     <= '0;
            r_written   <= '0;
            r_live      <= '0;
            r_rsp_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wired <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind       <= i_req.kind;
                        r_va         <= i_req.virt_addr;
                        r_is_write   <= i_req.is_write;
                        r_cur_asid   <= i_req.cur_asid;
                        r_hi         <= i_req.entry_hi;
                        r_mask       <= i_req.page_mask;
                        r_lo_even    <= i_req.entry_lo_even;
                        r_lo_odd     <= i_req.entry_lo_odd;
                        r_slot       <= SW'(i_req.slot);
                        r_s          <= (i_req.kind == K_WRITE_IDX) ? SW'(i_req.slot)
                                                                    : SW'(i_req.random_pick);
                        r_status     <= '0;
                        r_phys       <= '0;
                        r_dirty      <= 1'b0;
                        r_index_out  <= '0;
                        r_probe_miss <= 1'b0;
                        r_rd_hi      <= '0;
                        r_rd_mask    <= '0;
                        r_rd_lo_even <= '0;
                        r_rd_lo_odd  <= '0;
                        r_addr       <= '0;
                        r_pend       <= 1'b0;
                        r_found      <= 1'b0;
                        case (i_req.kind)
                            K_TRANSLATE, K_PROBE: r_state <= S_SCAN;
                            K_WRITE_IDX: r_state <= (SW'(i_req.slot) < SW'(ENTRIES)) ? S_WR
                                                                                     : S_OUT;
                            K_WRITE_RND: begin
                                r_state <= S_RMOD;
                            end
                            K_READ: r_state <= (SW'(i_req.slot) < SW'(ENTRIES)) ? S_RD : S_OUT;
                            K_CLEAR: begin
                                r_written <= '0;
                                r_live    <= '0;
                                r_state   <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Advance the read pointer; compare the entry read last cycle
                    r_pend <= scan_more;
                    r_cidx <= r_addr[IW-1:0];
                    if (scan_more) begin
                        r_addr <= r_addr + (IW + 1)'(1);
                    end
                    if (r_pend && cmp_match) begin
                        if (is_trans) begin
                            r_hit   <= ent;
                            r_state <= S_FIN;
                        end else if (!r_found) begin
                            r_found     <= 1'b1;
                            r_index_out <= 6'(r_cidx);
                        end else begin
                            // Drop the duplicate and finish
                            r_live[r_cidx] <= 1'b0;
                            r_state        <= S_OUT;
                        end
                    end else if (!r_pend && !scan_more) begin
                        if (is_trans) begin
                            r_status <= ST_MISS;
                        end else if (!r_found) begin
                            r_probe_miss <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_FIN: begin
                    r_status <= h_status;
                    r_phys   <= h_pfn | (r_va & h_m);
                    r_dirty  <= h_lo[2];
                    r_state  <= S_OUT;
                end
                S_RMOD: begin
                    // Reduce random_pick mod ENTRIES one subtraction per cycle
                    if (r_s >= SW'(ENTRIES)) begin
                        r_s <= r_s - SW'(ENTRIES);
                    end else begin
                        r_state <= S_RADJ;
                    end
                end
                S_RADJ: begin
                    r_s         <= adj_s;
                    r_index_out <= 6'(adj_s);
                    r_state     <= S_WR;
                end
                S_WR: begin
                    r_written[IW'(r_s)] <= 1'b1;
                    r_live[IW'(r_s)]    <= 1'b1;
                    r_state             <= S_OUT;
                end
                S_RD: begin
                    r_cidx  <= IW'(r_slot);
                    r_state <= S_RDOUT;
                end
                S_RDOUT: begin
                    r_rd_hi      <= 64'(e_vpn) | {56'd0, e_asid};
                    r_rd_mask    <= e_mask;
                    r_rd_lo_even <= e_lo_even;
                    r_rd_lo_odd  <= e_lo_odd;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    // Hold the response until the transfer completes
                    if (r_rsp_valid && o_rsp.ready) begin
                        r_rsp_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_rsp_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready              = (r_state == S_IDLE);
    assign o_rsp.valid              = r_rsp_valid;
    assign o_rsp.status             = r_status;
    assign o_rsp.phys_addr          = r_phys;
    assign o_rsp.dirty_prot         = r_dirty;
    assign o_rsp.index_out          = r_index_out;
    assign o_rsp.probe_miss         = r_probe_miss;
    assign o_rsp.read_entry_hi      = r_rd_hi;
    assign o_rsp.read_page_mask     = r_rd_mask;
    assign o_rsp.read_entry_lo_even = r_rd_lo_even;
    assign o_rsp.read_entry_lo_odd  = r_rd_lo_odd;

    `ASSERT_ALWAYS(a_live_written, i_clk, i_rst_n, (r_live & ~r_written) == '0, "live entry never written")
    `ASSERT_IMPL(a_ready_no_rsp, i_clk, i_rst_n, i_req.ready, !o_rsp.valid, "ready while response pending")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "ready right after a transfer")
    `ASSERT_ALWAYS(a_addr_range, i_clk, i_rst_n, r_addr <= (IW + 1)'(ENTRIES), "scan pointer past the last entry")
endmodule
